// ===== hdl/rfv_pkg.sv =====
// shared types, constants and crc function for the rtcm3 frame validator
package rfv_pkg;

  localparam logic [7:0]  SYNC_BYTE         = 8'hD3;
  localparam logic [7:0]  HDR_RESERVED_MASK = 8'hFC;
  localparam logic [10:0] MAX_FRAME         = 11'd1029;
  localparam logic [10:0] FRAME_OVERHEAD    = 11'd6;
  localparam logic [10:0] CRC_BYTES         = 11'd3;
  localparam logic [10:0] POS_MAX           = 11'd2047;
  localparam logic [23:0] CRC_POLY          = 24'h864CFB;

  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_BLE   = 2'd1;
  localparam logic [1:0] SRC_NTRIP = 2'd2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic       command;
    logic [1:0] source;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       queue_accepts;
  } frame_item_t;

  typedef struct packed {
    logic        verdict_valid;
    logic        frame_accepted;
    logic [31:0] accepted_total;
    logic [31:0] rejected_total;
    logic [31:0] age_ms;
  } result_item_t;

  // end-of-frame status from the frame checker
  typedef struct packed {
    logic ended;
    logic format_ok;
  } frame_end_t;

  // outcome handed to the statistics unit
  typedef struct packed {
    logic valid;
    logic accepted;
  } verdict_t;

  // crc-24q, msb first, one byte
  function automatic logic [23:0] crc_update(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      if (c[23]) begin
        c = {c[22:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[22:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/rfv_in_if.sv =====
// input channel: one frame byte or millisecond tick per transaction
interface rfv_in_if;
  logic                valid;
  logic                ready;
  rfv_pkg::frame_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/rfv_out_if.sv =====
// output channel: one result per input transaction
interface rfv_out_if;
  logic                 valid;
  logic                 ready;
  rfv_pkg::result_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/rfv_frame_check.sv =====
// frame state: header checks, length field, three byte delay line and crc
module rfv_frame_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output rfv_pkg::frame_end_t frame_end
);

  logic [10:0] byte_position, byte_position_next;
  logic        header_bad, header_bad_next;
  logic [9:0]  length_field, length_field_next;
  logic [23:0] tail_bytes, tail_bytes_next;
  logic [23:0] crc_register, crc_register_next;
  logic [10:0] length_total;

  always_comb begin
    header_bad_next   = header_bad;
    length_field_next = length_field;
    crc_register_next = crc_register;
    if (byte_position == 11'd0 && data_byte != rfv_pkg::SYNC_BYTE) begin
      header_bad_next = 1'b1;
    end
    if (byte_position == 11'd1) begin
      if ((data_byte & rfv_pkg::HDR_RESERVED_MASK) != 8'h00) begin
        header_bad_next = 1'b1;
      end
      length_field_next = {data_byte[1:0], 8'h00};
    end
    if (byte_position == 11'd2) begin
      length_field_next = {length_field[9:8], data_byte};
    end
    if (byte_position >= rfv_pkg::CRC_BYTES) begin
      crc_register_next = rfv_pkg::crc_update(crc_register, tail_bytes[23:16]);
    end
    tail_bytes_next = {tail_bytes[15:0], data_byte};
    byte_position_next = (byte_position < rfv_pkg::POS_MAX) ? byte_position + 11'd1
                                                            : byte_position;
  end

  assign length_total = {1'b0, length_field_next} + rfv_pkg::FRAME_OVERHEAD;

  always_comb begin
    frame_end.ended     = last_byte;
    frame_end.format_ok = !header_bad_next
                          && byte_position_next >= rfv_pkg::FRAME_OVERHEAD
                          && byte_position_next <= rfv_pkg::MAX_FRAME
                          && length_total == byte_position_next
                          && crc_register_next == tail_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_bad    <= 1'b0;
      length_field  <= '0;
      tail_bytes    <= '0;
      crc_register  <= '0;
    end else if (step) begin
      if (last_byte) begin
        byte_position <= '0;
        header_bad    <= 1'b0;
        length_field  <= '0;
        tail_bytes    <= '0;
        crc_register  <= '0;
      end else begin
        byte_position <= byte_position_next;
        header_bad    <= header_bad_next;
        length_field  <= length_field_next;
        tail_bytes    <= tail_bytes_next;
        crc_register  <= crc_register_next;
      end
    end
  end

endmodule

// ===== hdl/rfv_stats.sv =====
// millisecond clock, acceptance mark and outcome counters
module rfv_stats (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              tick,
  input  logic              sel_ok,
  input  rfv_pkg::verdict_t verdict,
  output logic [31:0]       accepted_total,
  output logic [31:0]       rejected_total,
  output logic [31:0]       age_ms
);

  logic [31:0] millisecond_clock, millisecond_clock_next;
  logic [31:0] accept_mark, accept_mark_next;
  logic        mark_valid, mark_valid_next;
  logic [31:0] accepted_count, accepted_count_next;
  logic [31:0] rejected_count, rejected_count_next;

  always_comb begin
    millisecond_clock_next = millisecond_clock + {31'd0, tick};
    accept_mark_next       = accept_mark;
    mark_valid_next        = mark_valid;
    accepted_count_next    = accepted_count;
    rejected_count_next    = rejected_count;
    if (verdict.valid) begin
      if (verdict.accepted) begin
        accept_mark_next    = millisecond_clock;
        mark_valid_next     = 1'b1;
        accepted_count_next = accepted_count + 32'd1;
      end else begin
        rejected_count_next = rejected_count + 32'd1;
      end
    end
  end

  assign accepted_total = accepted_count_next;
  assign rejected_total = rejected_count_next;
  // age reflects this transaction's update, so an accepting step reports zero
  assign age_ms = (!sel_ok || !mark_valid_next) ? 32'hFFFF_FFFF
                                                : millisecond_clock_next - accept_mark_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      millisecond_clock <= '0;
      accept_mark       <= '0;
      mark_valid        <= 1'b0;
      accepted_count    <= '0;
      rejected_count    <= '0;
    end else if (step) begin
      millisecond_clock <= millisecond_clock_next;
      accept_mark       <= accept_mark_next;
      mark_valid        <= mark_valid_next;
      accepted_count    <= accepted_count_next;
      rejected_count    <= rejected_count_next;
    end
  end

endmodule

// ===== hdl/rtcm3_frame_validator_unit.sv =====
// rtcm3 frame validator top level: input register, frame checks, result register
// a transaction passes through the input register and then the result register
// throughput: one transaction per cycle while result_out.ready is high; an input register and the result register
// let a new transaction in while a result waits to be taken
// reset: synchronous rst clears frame state, counters, clock and selected source
module rtcm3_frame_validator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  rfv_in_if.sink     frame_in,
  rfv_out_if.source  result_out
);

  logic [1:0]            selected_source;
  logic                  s1_valid;
  rfv_pkg::frame_item_t  s1_item;
  logic                  out_valid;
  rfv_pkg::result_item_t out_item;

  logic                  advance;
  logic                  out_free;
  logic                  byte_step;
  logic                  tick;
  logic                  sel_ok;
  logic                  source_ok;
  rfv_pkg::frame_end_t   frame_end;
  rfv_pkg::verdict_t     verdict;
  logic [31:0]           accepted_total;
  logic [31:0]           rejected_total;
  logic [31:0]           age_ms;

  assign out_free       = !out_valid || result_out.ready;
  assign advance        = s1_valid && out_free;
  assign frame_in.ready = !s1_valid || out_free;

  assign byte_step = advance && (s1_item.command == rfv_pkg::CMD_BYTE);
  assign tick      = s1_item.command == rfv_pkg::CMD_TICK;

  assign sel_ok    = selected_source == rfv_pkg::SRC_BLE
                     || selected_source == rfv_pkg::SRC_NTRIP;
  assign source_ok = sel_ok && s1_item.source == selected_source
                     && s1_item.source != rfv_pkg::SRC_NONE;

  rfv_frame_check u_frame_check (
    .clk       (clk),
    .rst       (rst),
    .step      (byte_step),
    .data_byte (s1_item.data_byte),
    .last_byte (s1_item.last_byte),
    .frame_end (frame_end)
  );

  always_comb begin
    verdict.valid    = !tick && frame_end.ended;
    verdict.accepted = verdict.valid && frame_end.format_ok && source_ok
                       && s1_item.queue_accepts;
  end

  rfv_stats u_stats (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .tick           (tick),
    .sel_ok         (sel_ok),
    .verdict        (verdict),
    .accepted_total (accepted_total),
    .rejected_total (rejected_total),
    .age_ms         (age_ms)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_source <= rfv_pkg::SRC_NONE;
    end else if (cfg_wr_en) begin
      selected_source <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_in.ready) begin
      s1_valid <= frame_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_in.ready && frame_in.valid) begin
      s1_item <= frame_in.item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.verdict_valid  <= verdict.valid;
      out_item.frame_accepted <= verdict.accepted;
      out_item.accepted_total <= accepted_total;
      out_item.rejected_total <= rejected_total;
      out_item.age_ms         <= age_ms;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.item  = out_item;

endmodule
